/* design/ssfl_pkg.sv */
// Shared types and constants of the slot store with free list.
// Holds the operation and status codes, the transaction payloads and the
// queue control structs. No dependencies.
package ssfl_pkg;

	localparam int SLOT_FIELD_BITS  = 8;
	localparam int VALUE_FIELD_BITS = 32;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_PUT     = 3'd1,
		OP_EXISTS  = 3'd2,
		OP_GET     = 3'd3,
		OP_SOFT    = 3'd4,
		OP_HARD    = 3'd5,
		OP_TAKE    = 3'd6,
		OP_CONFIRM = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TABLE_FULL  = 3'd1,
		ST_RANGE       = 3'd2,
		ST_QUEUE_EMPTY = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} status_t;

	// Queue select codes.
	localparam logic Q_FREE = 1'b0;
	localparam logic Q_PEND = 1'b1;

	typedef struct packed {
		op_t                         mode;
		logic [SLOT_FIELD_BITS-1:0]  slot;
		logic [VALUE_FIELD_BITS-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [SLOT_FIELD_BITS-1:0]  slot_out;
		logic [VALUE_FIELD_BITS-1:0] value_out;
		logic                        present;
		status_t                     status;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic sel;
	} queue_cmd_t;

	typedef struct packed {
		logic free_empty;
		logic free_full;
		logic pend_empty;
		logic pend_full;
	} queue_stat_t;

endpackage

/* design/ssfl_chan_if.sv */
// Valid/ready channels for the request and response transactions.
// Depends on ssfl_pkg for the payload types.
interface ssfl_req_if;
	logic              valid;
	logic              ready;
	ssfl_pkg::req_t    payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ssfl_rsp_if;
	logic              valid;
	logic              ready;
	ssfl_pkg::rsp_t    payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* design/slot_store_with_free_list.sv */
// Slot store with free list: slot table RAM plus free and pending slot queues.
// A request is accepted while idle and starts the RAM reads; the result register
// loads when it executes, which also does the write-back; a new request is taken
// only after that, and a stalled response holds the next request.
// Reset clears the fill count, queue pointers and handshake state at once; the
// RAMs are not cleared and requests are taken in the first cycle after reset.
module slot_store_with_free_list #(
	parameter int SLOT_COUNT = 256,
	parameter int VALUE_BITS = 32
) (
	input logic       clk,
	input logic       arst_n,
	ssfl_req_if.sink  req,
	ssfl_rsp_if.source rsp
);
	import ssfl_pkg::*;

	localparam int SLOT_BITS = $clog2(SLOT_COUNT);
	localparam int CNT_BITS  = $clog2(SLOT_COUNT + 1);
	localparam int CMP_BITS  = (CNT_BITS > SLOT_FIELD_BITS) ? CNT_BITS : SLOT_FIELD_BITS;

	logic                  busy_q, out_valid_q;
	logic [CNT_BITS-1:0]   fill_q;
	op_t                   op_s1;
	logic [SLOT_FIELD_BITS-1:0] slot_s1;
	logic [VALUE_BITS-1:0] val_s1;
	rsp_t                  rsp_q, rsp_d;

	logic accept, out_free, fire, in_range, table_open;

	logic                  sram_wr_want, sram_wr_en;
	logic [SLOT_BITS-1:0]  sram_wr_addr;
	logic [VALUE_BITS:0]   sram_wr_data, sram_rd_data;

	logic                  q_rd_sel;
	logic [SLOT_BITS-1:0]  q_rd_data;
	queue_cmd_t            qcmd_want, qcmd;
	queue_stat_t           qstat;
	logic                  fill_inc;

	ssfl_slot_ram #(
		.SLOT_COUNT(SLOT_COUNT),
		.VALUE_BITS(VALUE_BITS)
	) u_slot_ram (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(SLOT_BITS'(req.payload.slot)),
		.rd_data(sram_rd_data),
		.wr_en  (sram_wr_en),
		.wr_addr(sram_wr_addr),
		.wr_data(sram_wr_data)
	);

	ssfl_queues #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_queues (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_sel   (q_rd_sel),
		.rd_data  (q_rd_data),
		.cmd      (qcmd),
		.push_slot(SLOT_BITS'(slot_s1)),
		.stat     (qstat)
	);

	assign req.ready = !busy_q;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = rsp_q;

	always_comb begin
		accept     = req.valid && !busy_q;
		q_rd_sel   = (req.payload.mode == OP_TAKE) ? Q_PEND : Q_FREE;
		out_free   = !out_valid_q || rsp.ready;
		fire       = busy_q && out_free;
		in_range   = CMP_BITS'(slot_s1) < CMP_BITS'(fill_q);
		table_open = fill_q < CNT_BITS'(SLOT_COUNT);

		rsp_d          = '0;
		rsp_d.status   = ST_OK;
		sram_wr_want   = 1'b0;
		sram_wr_addr   = SLOT_BITS'(slot_s1);
		sram_wr_data   = {1'b1, val_s1};
		qcmd_want      = '0;
		qcmd_want.sel  = Q_FREE;
		fill_inc       = 1'b0;

		case (op_s1)
			OP_ADD: begin
				if (table_open) begin
					sram_wr_want   = 1'b1;
					sram_wr_addr   = fill_q[SLOT_BITS-1:0];
					fill_inc       = 1'b1;
					rsp_d.slot_out = SLOT_FIELD_BITS'(fill_q[SLOT_BITS-1:0]);
				end else if (!qstat.free_empty) begin
					// Table is full: reuse the oldest freed slot.
					sram_wr_want   = 1'b1;
					sram_wr_addr   = q_rd_data;
					qcmd_want.pop  = 1'b1;
					rsp_d.slot_out = SLOT_FIELD_BITS'(q_rd_data);
				end else begin
					rsp_d.status = ST_TABLE_FULL;
				end
			end
			OP_PUT: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					sram_wr_want = 1'b1;
				end
			end
			OP_EXISTS: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.present = sram_rd_data[VALUE_BITS];
				end
			end
			OP_GET: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					rsp_d.value_out = VALUE_FIELD_BITS'(sram_rd_data[VALUE_BITS-1:0]);
				end
			end
			OP_SOFT: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					sram_wr_want  = 1'b1;
					sram_wr_data  = {1'b0, sram_rd_data[VALUE_BITS-1:0]};
					qcmd_want.sel = Q_PEND;
					if (qstat.pend_full) begin
						rsp_d.status = ST_QUEUE_FULL;
					end else begin
						qcmd_want.push = 1'b1;
					end
				end
			end
			OP_HARD: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					sram_wr_want = 1'b1;
					sram_wr_data = '0;
					if (qstat.free_full) begin
						rsp_d.status = ST_QUEUE_FULL;
					end else begin
						qcmd_want.push = 1'b1;
					end
				end
			end
			OP_TAKE: begin
				qcmd_want.sel = Q_PEND;
				if (qstat.pend_empty) begin
					rsp_d.status = ST_QUEUE_EMPTY;
				end else begin
					qcmd_want.pop  = 1'b1;
					rsp_d.slot_out = SLOT_FIELD_BITS'(q_rd_data);
				end
			end
			OP_CONFIRM: begin
				if (!in_range) begin
					rsp_d.status = ST_RANGE;
				end else begin
					// The value is cleared but the used bit is kept.
					sram_wr_want = 1'b1;
					sram_wr_data = {sram_rd_data[VALUE_BITS], {VALUE_BITS{1'b0}}};
					if (qstat.free_full) begin
						rsp_d.status = ST_QUEUE_FULL;
					end else begin
						qcmd_want.push = 1'b1;
					end
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase

		sram_wr_en = sram_wr_want && fire;
		qcmd.push  = qcmd_want.push && fire;
		qcmd.pop   = qcmd_want.pop && fire;
		qcmd.sel   = qcmd_want.sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fill_q      <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Request capture and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.payload.mode;
			slot_s1 <= req.payload.slot;
			val_s1  <= VALUE_BITS'(req.payload.value_in);
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && !accept)
		else $error("request accepted while the previous one executes");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count moved by more than one");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		qcmd.push |-> ((qcmd.sel == Q_FREE) ? !qstat.free_full : !qstat.pend_full))
		else $error("push issued to a full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qcmd.pop |-> !qcmd.push &&
			((qcmd.sel == Q_FREE) ? !qstat.free_empty : !qstat.pend_empty))
		else $error("pop issued to an empty queue");

	a_rsp_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("response raised without an executing request");
`endif

endmodule

/* design/ssfl_slot_ram.sv */
// Slot table RAM: one entry per slot holding the used bit above the value.
// One write port and one registered read port. Depends on nothing.
module ssfl_slot_ram #(
	parameter int SLOT_COUNT = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
	output logic [VALUE_BITS:0]           rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(SLOT_COUNT)-1:0] wr_addr,
	input  logic [VALUE_BITS:0]           wr_data
);

	logic [VALUE_BITS:0] mem [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/ssfl_queues.sv */
// Free and pending slot queues sharing one RAM, each queue in its own half,
// with head pointers and counts in flip-flops. Depends on ssfl_pkg.
module ssfl_queues #(
	parameter int SLOT_COUNT = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic                          rd_sel,
	output logic [$clog2(SLOT_COUNT)-1:0] rd_data,
	input  ssfl_pkg::queue_cmd_t          cmd,
	input  logic [$clog2(SLOT_COUNT)-1:0] push_slot,
	output ssfl_pkg::queue_stat_t         stat
);
	import ssfl_pkg::*;

	localparam int SLOT_BITS = $clog2(SLOT_COUNT);
	localparam int CNT_BITS  = $clog2(SLOT_COUNT + 1);
	localparam int SUM_BITS  = CNT_BITS + 1;

	// The queue select is the top address bit, so each half spans the full index range.
	logic [SLOT_BITS-1:0] mem [2 << SLOT_BITS];

	logic [SLOT_BITS-1:0] free_head_q, pend_head_q;
	logic [CNT_BITS-1:0]  free_cnt_q, pend_cnt_q;
	logic [SLOT_BITS-1:0] push_idx;
	logic [SLOT_BITS-1:0] rd_idx;

	function automatic logic [SLOT_BITS-1:0] tail_of(
		input logic [SLOT_BITS-1:0] head,
		input logic [CNT_BITS-1:0]  cnt
	);
		logic [SUM_BITS-1:0] sum;
		sum = SUM_BITS'(head) + SUM_BITS'(cnt);
		if (sum >= SUM_BITS'(SLOT_COUNT)) begin
			sum = sum - SUM_BITS'(SLOT_COUNT);
		end
		return sum[SLOT_BITS-1:0];
	endfunction

	function automatic logic [SLOT_BITS-1:0] head_next(input logic [SLOT_BITS-1:0] head);
		return (head == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 : head + 1'b1;
	endfunction

	always_comb begin
		push_idx = (cmd.sel == Q_PEND) ? tail_of(pend_head_q, pend_cnt_q)
		                               : tail_of(free_head_q, free_cnt_q);
		rd_idx   = (rd_sel == Q_PEND) ? pend_head_q : free_head_q;
		stat.free_empty = (free_cnt_q == '0);
		stat.free_full  = (free_cnt_q == CNT_BITS'(SLOT_COUNT));
		stat.pend_empty = (pend_cnt_q == '0);
		stat.pend_full  = (pend_cnt_q == CNT_BITS'(SLOT_COUNT));
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[{cmd.sel, push_idx}] <= push_slot;
		end
		if (rd_en) begin
			rd_data <= mem[{rd_sel, rd_idx}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			pend_head_q <= '0;
			free_cnt_q  <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (cmd.sel == Q_FREE) begin
				if (cmd.push) begin
					free_cnt_q <= free_cnt_q + 1'b1;
				end else if (cmd.pop) begin
					free_cnt_q  <= free_cnt_q - 1'b1;
					free_head_q <= head_next(free_head_q);
				end
			end else begin
				if (cmd.push) begin
					pend_cnt_q <= pend_cnt_q + 1'b1;
				end else if (cmd.pop) begin
					pend_cnt_q  <= pend_cnt_q - 1'b1;
					pend_head_q <= head_next(pend_head_q);
				end
			end
		end
	end

endmodule
